// ===== hw/rtl/keyboard_report_key_event_diff_assert.svh =====
// Assertion macros for the keyboard report differ.
`ifndef KEYBOARD_REPORT_KEY_EVENT_DIFF_ASSERT_SVH
`define KEYBOARD_REPORT_KEY_EVENT_DIFF_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication, clocked on clk, off during reset
`define KBD_ASSERT_IMP(lbl, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error(msg);
// next-cycle implication
`define KBD_ASSERT_NEXT(lbl, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error(msg);
`else
`define KBD_ASSERT_IMP(lbl, a, b, msg)
`define KBD_ASSERT_NEXT(lbl, a, b, msg)
`endif
`endif

// ===== hw/rtl/kbd_diff_pkg.sv =====
// Shared types and constants for the keyboard report differ.
`timescale 1ns / 1ps
package kbd_diff_pkg;

    localparam int KEY_SLOTS = 6;
    localparam int KEY_W     = 8;
    localparam int EVT_W     = 2 * KEY_SLOTS;

    localparam logic [7:0] MOD_SHIFT_MASK = 8'h22;
    localparam logic [7:0] MOD_CTRL_MASK  = 8'h11;

    typedef enum logic {
        EV_PRESS   = 1'b0,
        EV_RELEASE = 1'b1
    } event_kind_t;

    typedef logic [KEY_SLOTS-1:0][KEY_W-1:0] key_arr_t;

    typedef struct packed {
        logic [KEY_SLOTS-1:0] press;
        logic [KEY_SLOTS-1:0] release_;
    } diff_mask_t;

endpackage

// ===== hw/rtl/keyboard_report_key_event_diff.sv =====
// Top level of the boot-keyboard report differ.
//
// Input channel (in_valid / in_stall): one boot-keyboard report per item,
// a modifier byte and six keycodes. Output channel (out_valid / out_stall):
// one key event per item, press or release, with last_event set on the
// final event of a report.
// On accept the report is compared against the stored keycodes and a mask
// of pending events (press then release, slot by slot) is loaded into the
// event buffer; the stored keycodes take the new report at the same edge.
// The buffer drains one event per cycle into the output register unless
// out_stall holds it, so the first event passes through the buffer and then
// the output register; a report has 0 to 12 events. The next report is taken
// in the cycle its predecessor's last event moves to the output register;
// a report with no events emits nothing.
// While out_stall is high and out_valid is set, the output register holds,
// the buffer holds and in_stall rises once a report's events are waiting.
// Reset clears the stored keycodes to zero and empties buffer and output.
`timescale 1ns / 1ps
`include "keyboard_report_key_event_diff_assert.svh"
module keyboard_report_key_event_diff
    import kbd_diff_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [KEY_W-1:0] modifiers,
    input  logic [KEY_W-1:0] key_slot0,
    input  logic [KEY_W-1:0] key_slot1,
    input  logic [KEY_W-1:0] key_slot2,
    input  logic [KEY_W-1:0] key_slot3,
    input  logic [KEY_W-1:0] key_slot4,
    input  logic [KEY_W-1:0] key_slot5,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             event_kind,
    output logic [KEY_W-1:0] event_key,
    output logic             shift_held,
    output logic             ctrl_held,
    output logic             last_event
);

    key_arr_t   new_keys;
    diff_mask_t mask;

    key_arr_t   prev_keys_reg;
    key_arr_t   old_keys_reg;
    logic [EVT_W-1:0] pend_reg, pend_next;
    logic       shift_reg;
    logic       ctrl_reg;

    logic       out_valid_reg, out_valid_next;
    event_kind_t kind_reg;
    logic [KEY_W-1:0] key_reg;
    logic       oshift_reg;
    logic       octrl_reg;
    logic       last_reg;

    logic       in_accept;
    logic       out_load;
    logic       emit;
    logic [EVT_W-1:0] pend_in;
    logic [EVT_W-1:0] pick;
    logic [EVT_W-1:0] rest;
    logic [KEY_W-1:0] pick_key;
    logic       pick_rel;

    assign new_keys[0] = key_slot0;
    assign new_keys[1] = key_slot1;
    assign new_keys[2] = key_slot2;
    assign new_keys[3] = key_slot3;
    assign new_keys[4] = key_slot4;
    assign new_keys[5] = key_slot5;

    kbd_diff_match u_match
    (
        .new_keys (new_keys),
        .old_keys (prev_keys_reg),
        .mask     (mask)
    );

    always_comb
    begin
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            pend_in[2*i]   = mask.press[i];
            pend_in[2*i+1] = mask.release_[i];
        end

        out_load = !out_valid_reg || !out_stall;
        // lowest pending event goes first
        pick     = pend_reg & (~pend_reg + EVT_W'(1));
        rest     = pend_reg & ~pick;

        // buffered new keys live in prev_keys_reg, old ones in old_keys_reg
        pick_key = '0;
        pick_rel = 1'b0;
        for (int j = 0; j < KEY_SLOTS; j++)
        begin
            pick_key = pick_key | ({KEY_W{pick[2*j]}} & prev_keys_reg[j])
                                | ({KEY_W{pick[2*j+1]}} & old_keys_reg[j]);
            pick_rel = pick_rel | pick[2*j+1];
        end

        emit      = out_load && (pend_reg != '0);
        in_stall  = (pend_reg != '0) && !(out_load && (rest == '0));
        in_accept = in_valid && !in_stall;

        if (in_accept)
            pend_next = pend_in;
        else if (emit)
            pend_next = rest;
        else
            pend_next = pend_reg;

        if (emit)
            out_valid_next = 1'b1;
        else if (out_load)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_keys_reg <= '0;
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (in_accept)
                prev_keys_reg <= new_keys;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            old_keys_reg <= prev_keys_reg;
            shift_reg    <= (modifiers & MOD_SHIFT_MASK) != '0;
            ctrl_reg     <= (modifiers & MOD_CTRL_MASK) != '0;
        end
        if (emit)
        begin
            kind_reg   <= pick_rel ? EV_RELEASE : EV_PRESS;
            key_reg    <= pick_key;
            oshift_reg <= shift_reg && !pick_rel;
            octrl_reg  <= ctrl_reg && !pick_rel;
            last_reg   <= (rest == '0);
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_kind = kind_reg;
    assign event_key  = key_reg;
    assign shift_held = oshift_reg;
    assign ctrl_held  = octrl_reg;
    assign last_event = last_reg;

    `KBD_ASSERT_NEXT(a_more_after_nonlast, out_valid_reg && !out_stall && !last_reg, out_valid_reg, "event stream broke before last")
    `KBD_ASSERT_IMP(a_key_nonzero, out_valid_reg, key_reg != '0, "event with empty keycode")
    `KBD_ASSERT_NEXT(a_pend_hold, (pend_reg != '0) && !out_load, pend_reg == $past(pend_reg), "pending events changed while stalled")

endmodule

// ===== hw/rtl/kbd_diff_match.sv =====
// Slot-against-slot keycode compare: finds new presses and releases.
`timescale 1ns / 1ps
module kbd_diff_match
    import kbd_diff_pkg::*;
(
    input  key_arr_t   new_keys,
    input  key_arr_t   old_keys,
    output diff_mask_t mask
);

    always_comb
    begin
        logic in_old;
        logic in_new;
        mask = '0;
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            in_old = 1'b0;
            in_new = 1'b0;
            for (int j = 0; j < KEY_SLOTS; j++)
            begin
                in_old = in_old | (old_keys[j] == new_keys[i]);
                in_new = in_new | (new_keys[j] == old_keys[i]);
            end
            // zero means empty slot and never makes an event
            mask.press[i]    = (new_keys[i] != '0) && !in_old;
            mask.release_[i] = (old_keys[i] != '0) && !in_new;
        end
    end

endmodule
